// ===== design/prg_pkg.sv =====
package prg_pkg;

  // Linear gain zone, in whole position units.
  localparam int unsigned LINEAR_ZONE = 20;

  // Width of a remainder modulo LINEAR_ZONE.
  localparam int unsigned LZ_W = $clog2(LINEAR_ZONE);

  // Reciprocal of LINEAR_ZONE scaled by 2^LZ_SHIFT and rounded up. Multiplying by it and
  // dropping LZ_SHIFT bits gives the exact quotient for any dividend below 2^31.
  localparam int unsigned LZ_SHIFT = 31 + LZ_W;
  localparam logic [31:0] LZ_MAGIC =
    32'(((64'd1 << LZ_SHIFT) + 64'(LINEAR_ZONE) - 64'd1) / 64'(LINEAR_ZONE));

  // Linear zone edge in raw Q16.16 units.
  localparam logic [32:0] ZONE_RAW = 33'(LINEAR_ZONE * 65536);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECELERATION_LIMIT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 31'd65536;

  // Step counts of the shared units.
  localparam logic [5:0] STEPS_MUL32 = 6'd32;
  localparam logic [5:0] STEPS_MUL16 = 6'd16;
  localparam logic [5:0] STEPS_SQRT  = 6'd32;

endpackage

// ===== design/position_ramp_generator_top.sv =====
// Trapezoidal position profiler. Each request carries a target position and a time step;
// the block answers with one new position and velocity (signed Q16.16) and keeps them as
// its state for the next request. One request is in work at a time: a shift-and-add
// multiplier (one bit per cycle) and a restoring square root (two bits per cycle) are
// stepped by a small sequencer, and the divide by the linear zone width runs on the same
// multiplier as a reciprocal product.
// The next request is taken once the result has moved into the output register.
module position_ramp_generator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [prg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [31:0]                    in_target_position,
  input  logic [15:0]                           in_time_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    out_position_out,
  output logic signed [31:0]                    out_velocity_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_VSQ, S_EMUL, S_PICK, S_GDIV, S_GFIX, S_GSQRT, S_LMUL, S_CSQRT,
    S_AMUL, S_SLEW, S_VPREP, S_VMUL, S_MOVE, S_DONE
  } state_t;

  state_t state_r;

  logic [30:0] vlim_r, alim_r, dlim_r;
  logic signed [31:0] pos_r, vel_r;
  logic signed [31:0] target_r;
  logic [15:0] dt_r;
  logic neg_r;
  logic [32:0] err_abs_r;
  logic [62:0] v2_r;
  logic [65:0] mc_r, prod_r;
  logic [31:0] mp_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [5:0] cnt_r;
  logic signed [31:0] desired_r, newvel_r, newpos_r;
  logic [30:0] maxchg_r;
  logic out_valid_r;
  logic signed [31:0] out_pos_r, out_vel_r;

  // Combinational step values.
  logic [30:0] decel;
  logic [31:0] twod;
  logic signed [32:0] err_c;
  logic [32:0] err_abs_c;
  logic [31:0] vmag_c, nvmag_c;
  logic [65:0] prod_nxt;
  logic [33:0] sq_t, sq_trial, rem_nxt;
  logic [31:0] root_nxt;
  logic [31:0] gq_c;
  logic [prg_pkg::LZ_W-1:0] gr_c;
  logic [prg_pkg::LZ_SHIFT:0] gf_c;
  logic near_c;
  logic signed [32:0] verr_c;
  logic [32:0] verr_abs_c;
  logic signed [33:0] slew_c, move_c;
  logic signed [31:0] newvel_c, newpos_c;
  logic out_free;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Applies the direction to a speed magnitude and clamps to the signed 32-bit range.
  function automatic logic signed [31:0] signed_speed(input logic [49:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (mag >= 50'h0_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag >= 50'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

  always_comb begin
    decel = (dlim_r == '0) ? 31'd1 : dlim_r;
    twod = {decel, 1'b0};
    err_c = {in_target_position[31], in_target_position} - {pos_r[31], pos_r};
    err_abs_c = err_c[32] ? 33'(-err_c) : 33'(err_c);
    vmag_c = vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
    nvmag_c = newvel_r[31] ? 32'(-newvel_r) : 32'(newvel_r);

    prod_nxt = prod_r + (mp_r[0] ? mc_r : 66'd0);

    sq_t = {rem_r[31:0], rad_r[63:62]};
    sq_trial = {root_r, 2'b01};
    if (sq_t >= sq_trial) begin
      rem_nxt = sq_t - sq_trial;
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt = sq_t;
      root_nxt = {root_r[30:0], 1'b0};
    end

    // 2*decel*2^16 / LINEAR_ZONE is decel*2^17 / LINEAR_ZONE: the whole part of decel over
    // the zone comes from the reciprocal product, the leftover is scaled the same way.
    gq_c = 32'(prod_r[63:prg_pkg::LZ_SHIFT]);
    gr_c = prg_pkg::LZ_W'({1'b0, decel} - 32'(gq_c * prg_pkg::LINEAR_ZONE));
    gf_c = (prg_pkg::LZ_SHIFT+1)'(gr_c) * (prg_pkg::LZ_SHIFT+1)'(prg_pkg::LZ_MAGIC);

    // Inside braking distance when |err| * 2 * decel <= v^2, or inside the linear zone.
    near_c = (prod_r[64:0] <= {2'b00, v2_r}) || (err_abs_r < prg_pkg::ZONE_RAW);

    verr_c = {desired_r[31], desired_r} - {vel_r[31], vel_r};
    verr_abs_c = verr_c[32] ? 33'(-verr_c) : 33'(verr_c);
    if (verr_c[32]) slew_c = {{2{vel_r[31]}}, vel_r} - {3'b000, maxchg_r};
    else slew_c = {{2{vel_r[31]}}, vel_r} + {3'b000, maxchg_r};
    if (verr_abs_c > {2'b00, maxchg_r}) newvel_c = sat32(slew_c);
    else newvel_c = desired_r;

    if (newvel_r[31]) move_c = {{2{pos_r[31]}}, pos_r} - {3'b000, prod_r[46:16]};
    else move_c = {{2{pos_r[31]}}, pos_r} + {3'b000, prod_r[46:16]};
    newpos_c = sat32(move_c);

    out_free = !out_valid_r || !out_stall;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_velocity_out = out_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r <= '0;
      vel_r <= '0;
      vlim_r <= prg_pkg::LIMIT_RESET;
      alim_r <= prg_pkg::LIMIT_RESET;
      dlim_r <= prg_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          prg_pkg::REG_VELOCITY_LIMIT:     vlim_r <= cfg_data;
          prg_pkg::REG_ACCELERATION_LIMIT: alim_r <= cfg_data;
          prg_pkg::REG_DECELERATION_LIMIT: dlim_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            target_r <= in_target_position;
            dt_r <= in_time_step;
            neg_r <= err_c[32];
            err_abs_r <= err_abs_c;
            mc_r <= {34'd0, vmag_c};
            mp_r <= vmag_c;
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL32;
            state_r <= S_VSQ;
          end
        end
        S_VSQ: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            v2_r <= prod_nxt[62:0];
            mc_r <= {33'd0, err_abs_r};
            mp_r <= twod;
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL32;
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= S_PICK;
        end
        S_PICK: begin
          rem_r <= '0;
          root_r <= '0;
          if (near_c) begin
            if (err_abs_r[32:16] == '0) begin
              // Close enough: land exactly on the target and stop.
              newvel_r <= '0;
              newpos_r <= target_r;
              state_r <= S_DONE;
            end else if (err_abs_r < prg_pkg::ZONE_RAW) begin
              mc_r <= {34'd0, prg_pkg::LZ_MAGIC};
              mp_r <= {1'b0, decel};
              prod_r <= '0;
              cnt_r <= prg_pkg::STEPS_MUL32;
              state_r <= S_GDIV;
            end else begin
              rad_r <= prod_r[63:0];
              cnt_r <= prg_pkg::STEPS_SQRT;
              state_r <= S_CSQRT;
            end
          end else begin
            desired_r <= signed_speed({19'd0, vlim_r}, neg_r);
            mc_r <= {35'd0, alim_r};
            mp_r <= {16'd0, dt_r};
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL16;
            state_r <= S_AMUL;
          end
        end
        S_GDIV: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= S_GFIX;
        end
        S_GFIX: begin
          rad_r <= {15'd0, gq_c, gf_c[prg_pkg::LZ_SHIFT-1 -: 17]};
          cnt_r <= prg_pkg::STEPS_SQRT;
          state_r <= S_GSQRT;
        end
        S_GSQRT: begin
          rad_r <= {rad_r[61:0], 2'b00};
          rem_r <= rem_nxt;
          root_r <= root_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            mc_r <= {33'd0, err_abs_r};
            mp_r <= root_nxt;
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL32;
            state_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            desired_r <= signed_speed(prod_nxt[65:16], neg_r);
            mc_r <= {35'd0, alim_r};
            mp_r <= {16'd0, dt_r};
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL16;
            state_r <= S_AMUL;
          end
        end
        S_CSQRT: begin
          rad_r <= {rad_r[61:0], 2'b00};
          rem_r <= rem_nxt;
          root_r <= root_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            desired_r <= signed_speed({18'd0, root_nxt}, neg_r);
            mc_r <= {35'd0, alim_r};
            mp_r <= {16'd0, dt_r};
            prod_r <= '0;
            cnt_r <= prg_pkg::STEPS_MUL16;
            state_r <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            maxchg_r <= prod_nxt[46:16];
            state_r <= S_SLEW;
          end
        end
        S_SLEW: begin
          newvel_r <= newvel_c;
          state_r <= S_VPREP;
        end
        S_VPREP: begin
          mc_r <= {34'd0, nvmag_c};
          mp_r <= {16'd0, dt_r};
          prod_r <= '0;
          cnt_r <= prg_pkg::STEPS_MUL16;
          state_r <= S_VMUL;
        end
        S_VMUL: begin
          prod_r <= prod_nxt;
          mc_r <= {mc_r[64:0], 1'b0};
          mp_r <= {1'b0, mp_r[31:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= S_MOVE;
        end
        S_MOVE: begin
          newpos_r <= newpos_c;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_pos_r <= newpos_r;
            out_vel_r <= newvel_r;
            out_valid_r <= 1'b1;
            pos_r <= newpos_r;
            vel_r <= newvel_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_VSQ)
    else $error("accepted request did not start the sequence");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result was not registered");

  a_unit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VSQ || state_r == S_EMUL || state_r == S_GDIV || state_r == S_GSQRT ||
     state_r == S_LMUL || state_r == S_CSQRT || state_r == S_AMUL || state_r == S_VMUL)
    |-> cnt_r != 6'd0)
    else $error("shared unit running with an empty step count");

  a_snap_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) && near_c && (err_abs_r[32:16] == '0)
    |=> (newvel_r == '0) && (newpos_r == target_r) && (state_r == S_DONE))
    else $error("snap onto target did not stop the motion");

endmodule
